// ===== rtl/core/evs_pkg.sv =====
// Shared types and constants for the energy VAD segmenter.
// No dependencies; imported by evs_core and energy_vad_segmenter.
package evs_pkg;

    localparam int FRAME_BITS_DEF = 32;

    localparam int ENERGY_W   = 32;
    localparam int HANGOVER_W = 8;
    localparam int START_W    = 32;
    localparam int END_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [ENERGY_W-1:0]   THRESHOLD_RST = 32'd327680;
    localparam logic [HANGOVER_W-1:0] HANGOVER_RST  = 8'd10;
    localparam logic [HANGOVER_W-1:0] RUN_MAX       = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_HANGOVER  = 2'd1
    } t_reg_idx;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef struct packed {
        logic                operation;
        logic [ENERGY_W-1:0] energy;
    } t_in_item;

    typedef struct packed {
        logic signed [START_W-1:0] segment_start;
        logic [END_W-1:0]          segment_end;
        logic                      closed_by_flush;
    } t_out_item;

    typedef struct packed {
        logic [ENERGY_W-1:0]   threshold;
        logic [HANGOVER_W-1:0] hangover;
    } t_cfg;

endpackage

// ===== rtl/core/evs_core.sv =====
// Next-state and result logic of the segmenter for one request.
// Depends on evs_pkg; state registers live in energy_vad_segmenter.
module evs_core import evs_pkg::*; #(
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  t_in_item                i_item,
    input  t_cfg                    i_cfg,
    input  logic                    i_in_speech,
    input  logic [HANGOVER_W-1:0]   i_run_count,
    input  logic [FRAME_BITS-1:0]   i_frame_index,
    input  logic [FRAME_BITS-1:0]   i_start_index,
    output logic                    o_in_speech,
    output logic [HANGOVER_W-1:0]   o_run_count,
    output logic [FRAME_BITS-1:0]   o_frame_index,
    output logic [FRAME_BITS-1:0]   o_start_index,
    output logic                    o_emit,
    output t_out_item               o_result
);

    logic [HANGOVER_W-1:0]       h;
    logic [FRAME_BITS-1:0]       h_ext;
    logic                        loud;
    logic [FRAME_BITS-1:0]       fi_inc;
    logic [FRAME_BITS-1:0]       fi_back;
    logic [HANGOVER_W-1:0]       run_inc;
    logic [FRAME_BITS-1:0]       res_start;
    logic [FRAME_BITS-1:0]       res_end;
    logic                        res_flush;
    logic [FRAME_BITS+START_W-1:0] start_wide;
    logic [FRAME_BITS+END_W-1:0]   end_wide;

    assign h       = (i_cfg.hangover == '0) ? HANGOVER_W'(1) : i_cfg.hangover;
    assign h_ext   = {{(FRAME_BITS-HANGOVER_W){1'b0}}, h};
    assign loud    = i_item.energy > i_cfg.threshold;
    assign fi_inc  = i_frame_index + FRAME_BITS'(1);
    assign fi_back = fi_inc - h_ext;
    assign run_inc = (i_run_count < RUN_MAX) ? i_run_count + HANGOVER_W'(1) : i_run_count;

    always_comb begin
        o_in_speech   = i_in_speech;
        o_run_count   = i_run_count;
        o_frame_index = i_frame_index;
        o_start_index = i_start_index;
        o_emit        = 1'b0;
        res_start     = i_start_index;
        res_end       = i_frame_index;
        res_flush     = 1'b1;
        if (i_item.operation == OP_FLUSH) begin
            o_emit = i_in_speech;
        end else begin
            o_frame_index = fi_inc;
            if (!i_in_speech) begin
                if (loud) begin
                    if (run_inc >= h) begin
                        o_run_count   = h;
                        o_start_index = fi_back;
                        o_in_speech   = 1'b1;
                    end else begin
                        o_run_count = run_inc;
                    end
                end else begin
                    o_run_count = '0;
                end
            end else if (loud) begin
                o_run_count = h;
            end else if (i_run_count <= HANGOVER_W'(1)) begin
                o_run_count = '0;
                o_in_speech = 1'b0;
                o_emit      = 1'b1;
                res_end     = fi_back;
                res_flush   = 1'b0;
            end else begin
                o_run_count = i_run_count - HANGOVER_W'(1);
            end
        end
    end

    assign start_wide = {{START_W{1'b0}}, res_start};
    assign end_wide   = {{END_W{1'b0}}, res_end};

    assign o_result.segment_start   = $signed(start_wide[START_W-1:0]);
    assign o_result.segment_end     = end_wide[END_W-1:0];
    assign o_result.closed_by_flush = res_flush;

endmodule

// ===== rtl/core/energy_vad_segmenter.sv =====
// Energy-threshold VAD segmenter: top level with state, config and result register.
// A result is valid in the cycle after its request is accepted.
// One request per cycle unless stalled; the result register is the only stage.
// Input stalls only while a result is held and the output is stalled.
// Synchronous active-low reset restarts segment state and loads register defaults.
// Depends on evs_pkg and evs_core.
module energy_vad_segmenter import evs_pkg::*; #(
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                  r_cfg;
    logic                  r_in_speech;
    logic [HANGOVER_W-1:0] r_run_count;
    logic [FRAME_BITS-1:0] r_frame_index;
    logic [FRAME_BITS-1:0] r_start_index;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  n_in_speech;
    logic [HANGOVER_W-1:0] n_run_count;
    logic [FRAME_BITS-1:0] n_frame_index;
    logic [FRAME_BITS-1:0] n_start_index;
    logic                  emit;
    t_out_item             result;
    logic                  out_load;
    logic                  in_acc;

    evs_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .i_item        (i_in_item),
        .i_cfg         (r_cfg),
        .i_in_speech   (r_in_speech),
        .i_run_count   (r_run_count),
        .i_frame_index (r_frame_index),
        .i_start_index (r_start_index),
        .o_in_speech   (n_in_speech),
        .o_run_count   (n_run_count),
        .o_frame_index (n_frame_index),
        .o_start_index (n_start_index),
        .o_emit        (emit),
        .o_result      (result)
    );

    assign out_load    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !out_load;
    assign in_acc      = i_in_valid && out_load;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THRESHOLD_RST;
            r_cfg.hangover  <= HANGOVER_RST;
            r_in_speech     <= 1'b0;
            r_run_count     <= '0;
            r_frame_index   <= '1;
            r_start_index   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_THRESHOLD: r_cfg.threshold <= i_cfg_data;
                    REG_HANGOVER:  r_cfg.hangover  <= i_cfg_data[HANGOVER_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_in_speech   <= n_in_speech;
                r_run_count   <= n_run_count;
                r_frame_index <= n_frame_index;
                r_start_index <= n_start_index;
            end
            if (out_load) begin
                r_out_valid <= in_acc && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= result;
        end
    end

endmodule

// ===== verif/tb_energy_vad_segmenter.sv =====
// Self-checking testbench for energy_vad_segmenter: directed and randomized frame traffic,
// with a local segment predictor checked against every emitted segment.
// Depends on evs_pkg and the energy_vad_segmenter RTL.
`timescale 1ns / 100ps

module tb_energy_vad_segmenter;
    import evs_pkg::*;

    localparam int FRAME_W = FRAME_BITS_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_item   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;
    logic                  o_cfg_ready;

    logic [ENERGY_W-1:0]   vad_threshold = THRESHOLD_RST;
    logic [HANGOVER_W-1:0] vad_hangover  = HANGOVER_RST;
    bit                    vad_speech    = 1'b0;
    logic [HANGOVER_W-1:0] vad_run       = '0;
    logic [FRAME_W-1:0]    vad_frame     = '1;
    logic [FRAME_W-1:0]    vad_start     = '0;

    t_out_item pending_segments[$];
    t_out_item seg_want;
    int        mismatch_count = 0;
    bit        gaps_on  = 1'b1;
    bit        stall_on = 1'b1;
    int        stall_left = 0;
    int        stall_roll;

    energy_vad_segmenter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit predict_segment(input t_in_item req, output t_out_item seg);
        logic [HANGOVER_W-1:0] h;
        logic [FRAME_W-1:0]    tail;
        bit                    loud;
        h = (vad_hangover == '0) ? 8'd1 : vad_hangover;
        seg = '0;
        if (req.operation == OP_FLUSH) begin
            if (!vad_speech) return 1'b0;
            seg.segment_start   = vad_start[START_W-1:0];
            seg.segment_end     = vad_frame[END_W-1:0];
            seg.closed_by_flush = 1'b1;
            return 1'b1;
        end
        vad_frame = vad_frame + 1'b1;
        loud = req.energy > vad_threshold;
        if (!vad_speech) begin
            if (loud) begin
                if (vad_run != RUN_MAX) vad_run = vad_run + 1'b1;
                if (vad_run >= h) begin
                    vad_run    = h;
                    vad_start  = vad_frame - h;
                    vad_speech = 1'b1;
                end
            end else begin
                vad_run = '0;
            end
            return 1'b0;
        end
        if (loud) begin
            vad_run = h;
            return 1'b0;
        end
        if (vad_run <= 8'd1) begin
            vad_run    = '0;
            vad_speech = 1'b0;
            tail = vad_frame - h;
            seg.segment_start   = vad_start[START_W-1:0];
            seg.segment_end     = tail[END_W-1:0];
            seg.closed_by_flush = 1'b0;
            return 1'b1;
        end
        vad_run = vad_run - 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [ENERGY_W-1:0] loud_energy();
        if (vad_threshold == '1) return '1;
        if ($urandom_range(0, 1) == 0) return vad_threshold + 1'b1;
        return $urandom_range(32'hFFFF_FFFF, vad_threshold + 1'b1);
    endfunction

    function automatic logic [ENERGY_W-1:0] quiet_energy();
        if ($urandom_range(0, 9) < 3) return vad_threshold;
        return $urandom_range(vad_threshold, 0);
    endfunction

    task automatic send_request(input t_op op, input logic [ENERGY_W-1:0] energy);
        int        gap;
        int        roll;
        t_in_item  req;
        t_out_item seg;
        gap = 0;
        if (gaps_on) begin
            roll = $urandom_range(0, 99);
            if (roll >= 90) gap = $urandom_range(5, 20);
            else if (roll >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.operation = op;
        req.energy    = energy;
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_segment(req, seg)) pending_segments = {pending_segments, seg};
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_THRESHOLD) vad_threshold = data;
        else if (idx == REG_HANGOVER) vad_hangover = data[HANGOVER_W-1:0];
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_segments.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_start_minus_one();
        write_reg(REG_HANGOVER, 32'h0000_0001);
        i_cfg_valid <= 1'b0;
        send_request(OP_FRAME, 32'hFFFF_FFFF);
        send_request(OP_FLUSH, 32'h0000_0000);
        send_request(OP_FRAME, THRESHOLD_RST);
        send_request(OP_FLUSH, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_threshold_extremes();
        write_reg(REG_THRESHOLD, 32'h0000_0000);
        write_reg(REG_HANGOVER, 32'hFFFF_FF00);
        i_cfg_valid <= 1'b0;
        send_request(OP_FRAME, 32'h0000_0000);
        send_request(OP_FRAME, 32'h0000_0001);
        send_request(OP_FRAME, 32'h5555_AAAA);
        send_request(OP_FRAME, 32'h0000_0000);
        wait_idle();
        write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        send_request(OP_FRAME, 32'hFFFF_FFFF);
        send_request(OP_FLUSH, 32'hAAAA_5555);
        wait_idle();
    endtask

    task automatic test_counter_above_hangover();
        write_reg(REG_THRESHOLD, 32'h0000_0000);
        write_reg(REG_HANGOVER, 32'h0000_00FF);
        i_cfg_valid <= 1'b0;
        repeat (5) send_request(OP_FRAME, $urandom_range(32'hFFFF_FFFF, 1));
        wait_idle();
        write_reg(REG_HANGOVER, 32'h0000_0003);
        i_cfg_valid <= 1'b0;
        send_request(OP_FRAME, 32'h8000_0000);
        send_request(OP_FLUSH, 32'h0000_0000);
        send_request(OP_FRAME, 32'h0000_FFFF);
        repeat (3) send_request(OP_FRAME, 32'h0000_0000);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [ENERGY_W-1:0]   thr;
        logic [CFG_DATA_W-1:0] hang_data;
        int                    roll;
        int                    hang_eff;
        int                    run_len;
        int                    sent;
        for (int phase = 0; phase < 10; phase++) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) thr = '0;
            else if (roll < 25) thr = '1;
            else if (roll < 55) thr = $urandom();
            else thr = $urandom_range(32'h000A_0000, 0);
            hang_data = $urandom();
            roll = $urandom_range(0, 99);
            if (roll < 10) hang_data[HANGOVER_W-1:0] = '0;
            else if (roll < 30) hang_data[HANGOVER_W-1:0] = 8'd1;
            else if (roll < 85) hang_data[HANGOVER_W-1:0] = HANGOVER_W'($urandom_range(8, 2));
            else hang_data[HANGOVER_W-1:0] = HANGOVER_W'($urandom_range(30, 9));
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_THRESHOLD, thr);
                write_reg(REG_HANGOVER, hang_data);
            end else begin
                write_reg(REG_HANGOVER, hang_data);
                write_reg(REG_THRESHOLD, thr);
            end
            if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, $urandom());
            i_cfg_valid <= 1'b0;
            hang_eff = (vad_hangover == '0) ? 1 : vad_hangover;
            sent = 0;
            while (sent < 75) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    run_len = hang_eff - 1 + $urandom_range(0, 3);
                    if ($urandom_range(0, 9) == 0) run_len = run_len + $urandom_range(1, 15);
                    repeat (run_len) send_request(OP_FRAME, loud_energy());
                    sent += run_len;
                end else if (roll < 85) begin
                    run_len = $urandom_range(hang_eff + 2, 1);
                    repeat (run_len) send_request(OP_FRAME, quiet_energy());
                    sent += run_len;
                end else if (roll < 93) begin
                    send_request(OP_FLUSH, $urandom());
                    sent++;
                end else begin
                    send_request(OP_FRAME, $urandom());
                    sent++;
                end
            end
            wait_idle();
        end
    endtask

    always @(posedge i_clk) begin
        if (!stall_on) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70) begin
                i_out_stall <= 1'b0;
            end else begin
                stall_left = (stall_roll < 95) ? $urandom_range(2, 0) : $urandom_range(29, 7);
                i_out_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_segments.size() == 0) begin
                $error("segment with none pending: start %0d, end %0d, closed_by_flush %0d",
                       o_out_item.segment_start, o_out_item.segment_end,
                       o_out_item.closed_by_flush);
                mismatch_count++;
            end else begin
                seg_want = pending_segments.pop_front();
                if (o_out_item.segment_start !== seg_want.segment_start) begin
                    $error("segment_start: expected %0d, got %0d",
                           seg_want.segment_start, o_out_item.segment_start);
                    mismatch_count++;
                end
                if (o_out_item.segment_end !== seg_want.segment_end) begin
                    $error("segment_end: expected %0d, got %0d",
                           seg_want.segment_end, o_out_item.segment_end);
                    mismatch_count++;
                end
                if (o_out_item.closed_by_flush !== seg_want.closed_by_flush) begin
                    $error("closed_by_flush: expected %0d, got %0d",
                           seg_want.closed_by_flush, o_out_item.closed_by_flush);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_start_minus_one();
        test_threshold_extremes();
        test_counter_above_hangover();
        test_random_traffic();
        if (mismatch_count == 0) begin
            $display("tb_energy_vad_segmenter: done, clean");
        end else begin
            $display("tb_energy_vad_segmenter: done, errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_energy_vad_segmenter: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/evs_pkg.sv
rtl/core/evs_core.sv
rtl/core/energy_vad_segmenter.sv
verif/tb_energy_vad_segmenter.sv
